// ===== hdl/gda_pkg.sv =====
// package for the gregorian date arithmetic block
// types, constants, reciprocal factors and calendar tables; no dependencies
`default_nettype none
package gda_pkg;

  localparam int unsigned MaxYear = 9999;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 48;

  localparam logic signed [25:0] DistMax = 26'sd4194303;
  localparam logic signed [25:0] DistMin = -26'sd4194304;

  // days from 0000-03-01 back to 0000-01-01, plus one era
  localparam logic signed [25:0] EraBias = 26'sd146037;

  typedef enum logic {
    REQ_DIFF   = 1'b0,
    REQ_OFFSET = 1'b1
  } req_e;

  // reciprocal factors: x / D == (x * M) >> S for x below the noted width
  localparam int unsigned         S100a  = 22;  // x < 2**15
  localparam logic [25:0]         M100a  = 26'(((64'd1 << 22) + 64'd99) / 64'd100);
  localparam int unsigned         SEra   = 42;  // x < 2**24
  localparam logic [25:0]         MEra   = 26'(((64'd1 << 42) + 64'd146096) / 64'd146097);
  localparam int unsigned         S1460  = 29;  // x < 2**18
  localparam logic [25:0]         M1460  = 26'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam int unsigned         S36524 = 34;
  localparam logic [25:0]         M36524 = 26'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam int unsigned         S146096 = 36;
  localparam logic [25:0]         M146096 = 26'(((64'd1 << 36) + 64'd146095) / 64'd146096);
  localparam int unsigned         S365   = 27;
  localparam logic [25:0]         M365   = 26'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam int unsigned         S153   = 19;  // x < 2**11
  localparam logic [25:0]         M153   = 26'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam int unsigned         S100b  = 16;  // x < 2**9
  localparam logic [25:0]         M100b  = 26'(((64'd1 << 16) + 64'd99) / 64'd100);

  typedef struct packed {
    logic [22:0] y365;
    logic [12:0] q4;
    logic [7:0]  q100;
    logic [5:0]  q400;
    logic [8:0]  cum;
    logic        leap_add;
    logic [4:0]  day;
  } date_terms_t;

  function automatic logic [24:0] div_c(input logic [24:0] x, input logic [25:0] m,
                                        input int unsigned s);
    logic [50:0] p;
    p = 51'(x) * 51'(m);
    return 25'(p >> s);
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      default: c = 9'd334;
    endcase
    return c;
  endfunction

  // first day of year of each month, counted from march
  function automatic logic [8:0] mar_start(input logic [3:0] mp);
    logic [8:0] c;
    case (mp)
      4'd0:    c = 9'd0;
      4'd1:    c = 9'd31;
      4'd2:    c = 9'd61;
      4'd3:    c = 9'd92;
      4'd4:    c = 9'd122;
      4'd5:    c = 9'd153;
      4'd6:    c = 9'd184;
      4'd7:    c = 9'd214;
      4'd8:    c = 9'd245;
      4'd9:    c = 9'd275;
      4'd10:   c = 9'd306;
      default: c = 9'd337;
    endcase
    return c;
  endfunction

  function automatic date_terms_t date_terms(input logic [3:0] m, input logic [4:0] d,
                                             input logic [13:0] y);
    date_terms_t t;
    logic [3:0]  mc;
    logic [24:0] q_y, q_y99, q_y399;
    logic        div100, leap;
    mc     = (m == 4'd0) ? 4'd1 : ((m > 4'd12) ? 4'd12 : m);
    q_y    = div_c(25'(y), M100a, S100a);
    q_y99  = div_c(25'(y) + 25'd99, M100a, S100a);
    q_y399 = div_c(25'(y) + 25'd399, M100a, S100a);
    div100 = (q_y == q_y99);
    leap   = (y[1:0] == 2'b00) && (!div100 || (q_y[1:0] == 2'b00));
    t.y365     = 23'(23'(y) * 23'd365);
    t.q4       = 13'((15'(y) + 15'd3) >> 2);
    t.q100     = q_y99[7:0];
    t.q400     = q_y399[7:2];
    t.cum      = cum_days(mc);
    t.leap_add = (mc > 4'd2) && leap;
    t.day      = d;
    return t;
  endfunction

  function automatic logic signed [25:0] day_num(input date_terms_t t);
    return $signed(26'(t.y365)) + $signed(26'(t.q4)) - $signed(26'(t.q100))
         + $signed(26'(t.q400)) + $signed(26'(t.cum)) + $signed(26'(t.leap_add))
         + $signed(26'(t.day)) - 26'sd1;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/gregorian_date_arithmetic_top.sv =====
// gregorian date difference and day offset, ten stage pipeline
// depends on gda_pkg
//
// channel   dir  tdata (low bit up)                                     tuser
// s_axis    in   first m/d/y, second m/d/y, day_offset                 req_type
// m_axis    out  distance_days, result_month, result_day, result_year range_error
//
// one item can enter every cycle while the output is not stalled; the whole pipeline advances together
// a stalled output freezes every stage, so nothing is lost or repeated
// reset clears the valid bits only
`default_nettype none
module gregorian_date_arithmetic_top import gda_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // first_month, first_day, first_year, second_month, second_day, second_year, day_offset
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  // req_type
  input  wire logic                 s_axis_tuser,
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // distance_days, result_month, result_day, result_year
  output      logic [OutDataW-1:0]  m_axis_tdata,
  // range_error
  output      logic                 m_axis_tuser
);

  localparam int unsigned NStages = 10;

  logic [NStages-1:0] v_q, v_d;
  logic               en;

  assign en            = !v_q[NStages-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign v_d           = {v_q[NStages-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  // stage payloads
  req_e                 rq_q [NStages-1];
  date_terms_t          ta_q, tb_q;
  logic signed [22:0]   off1_q, off2_q;
  logic signed [25:0]   na_q, nb_q;
  logic signed [22:0]   dist_q [3:NStages];
  logic                 neg_q [3:NStages];
  logic [23:0]          z3_q, z4_q;
  logic [6:0]           era_q [4:NStages-1];
  logic [17:0]          doe_q [5:7];
  logic [17:0]          t6_q;
  logic [8:0]           yoe_q [7:9];
  logic [8:0]           doy_q [8:9];
  logic [3:0]           mp9_q;
  logic [3:0]           mon_q;
  logic [4:0]           day_q;
  logic [13:0]          year_q;

  req_e                 req_in;
  logic signed [25:0]   diff_d, sum_d;
  logic signed [22:0]   dist_d;
  logic [24:0]          era_d;
  logic [17:0]          doe_d, t_d;
  logic [24:0]          yoe_d, mp_d;
  logic [8:0]           doy_d;
  logic signed [16:0]   y_full;
  logic [3:0]           mon_d;
  logic [4:0]           day_d;
  logic                 err_d;

  assign req_in = req_e'(s_axis_tuser);

  always_comb begin
    diff_d = nb_q - na_q;
    if (diff_d > DistMax) begin
      dist_d = 23'(DistMax);
    end else if (diff_d < DistMin) begin
      dist_d = 23'(DistMin);
    end else begin
      dist_d = 23'(diff_d);
    end
    sum_d   = na_q + 26'(off2_q);
    era_d   = div_c(25'(z3_q), MEra, SEra);
    doe_d   = 18'(z4_q - 24'(era_q[4] * 18'd146097));
    t_d     = 18'(doe_q[5] - 18'(div_c(25'(doe_q[5]), M1460, S1460))
            + 18'(div_c(25'(doe_q[5]), M36524, S36524))
            - 18'(div_c(25'(doe_q[5]), M146096, S146096)));
    yoe_d   = div_c(25'(t6_q), M365, S365);
    doy_d   = 9'(doe_q[7] - 18'(yoe_q[7] * 18'd365) - 18'(yoe_q[7] >> 2)
            + 18'(div_c(25'(yoe_q[7]), M100b, S100b)));
    mp_d    = div_c(25'(12'(doy_q[8] * 12'd5) + 12'd2), M153, S153);
    mon_d   = (mp9_q < 4'd10) ? mp9_q + 4'd3 : mp9_q - 4'd9;
    day_d   = 5'(doy_q[9] - mar_start(mp9_q) + 9'd1);
    y_full  = $signed(17'(era_q[9] * 17'd400)) + $signed(17'(yoe_q[9]))
            - 17'sd400 + ((mp9_q >= 4'd10) ? 17'sd1 : 17'sd0);
    err_d   = neg_q[9] || (y_full < 0) || (y_full > $signed(17'(MaxYear)));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rq_q[0]   <= req_in;
      ta_q      <= date_terms(s_axis_tdata[3:0], s_axis_tdata[8:4], s_axis_tdata[22:9]);
      tb_q      <= date_terms(s_axis_tdata[26:23], s_axis_tdata[31:27], s_axis_tdata[45:32]);
      off1_q    <= $signed(s_axis_tdata[68:46]);
      for (int i = 1; i < NStages - 1; i++) begin
        rq_q[i] <= rq_q[i-1];
      end
      // stage 2: day numbers
      na_q      <= day_num(ta_q);
      nb_q      <= day_num(tb_q);
      off2_q    <= off1_q;
      // stage 3: difference and offset sum
      dist_q[3] <= dist_d;
      neg_q[3]  <= sum_d < 0;
      z3_q      <= 24'(sum_d + EraBias);
      for (int i = 4; i < NStages; i++) begin
        dist_q[i] <= dist_q[i-1];
        neg_q[i]  <= neg_q[i-1];
      end
      // stage 4..9: era, day of era, year of era, day of year, march month
      z4_q      <= z3_q;
      era_q[4]  <= era_d[6:0];
      for (int i = 5; i < NStages; i++) begin
        era_q[i] <= era_q[i-1];
      end
      doe_q[5]  <= doe_d;
      t6_q      <= t_d;
      doe_q[6]  <= doe_q[5];
      doe_q[7]  <= doe_q[6];
      yoe_q[7]  <= yoe_d[8:0];
      yoe_q[8]  <= yoe_q[7];
      yoe_q[9]  <= yoe_q[8];
      doy_q[8]  <= doy_d;
      doy_q[9]  <= doy_q[8];
      mp9_q     <= mp_d[3:0];
      // output register
      if (rq_q[8] == REQ_OFFSET && !err_d) begin
        mon_q  <= mon_d;
        day_q  <= day_d;
        year_q <= 14'(y_full);
      end else begin
        mon_q  <= '0;
        day_q  <= '0;
        year_q <= '0;
      end
      neg_q[NStages] <= (rq_q[8] == REQ_OFFSET) && err_d;
      dist_q[NStages] <= (rq_q[8] == REQ_DIFF) ? dist_q[9] : '0;
    end
  end

  assign m_axis_tvalid = v_q[NStages-1];
  assign m_axis_tdata  = {2'b00, year_q, day_q, mon_q, dist_q[NStages]};
  assign m_axis_tuser  = neg_q[NStages];

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[45:23] == '0))
    else $error("range error item carries a date");
  a_err_nodist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[22:0] == '0))
    else $error("range error item carries a distance");
  a_date_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[26:23] != '0) |->
      (m_axis_tdata[26:23] <= 4'd12) && (m_axis_tdata[31:27] != '0)
      && (m_axis_tdata[22:0] == '0))
    else $error("offset result date malformed");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(v_q))
    else $error("pipeline moved during output stall");
`endif

endmodule
`default_nettype wire
